// ----- rtl/core/hspc_pkg.sv -----
// ----------------------------------------------------------------------------
// hspc_pkg
// Shared types, codes and constants of the hard-sphere pair collision block.
// ----------------------------------------------------------------------------
`default_nettype none

package hspc_pkg;

  // Fixed-point format of all values
  localparam int FRAC_BITS = 16;
  localparam int VAL_W     = 32;
  localparam int REG_W     = 31;

  // Iterative divider geometry: dividend is left-aligned in DIV_W bits
  localparam int DIV_W     = 84;
  localparam int DEN_W     = 63;
  localparam int DIV_CNT_W = 7;

  // Input operation codes
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_COLLIDE = 1'b1;

  // Zone codes
  localparam logic [2:0] ZONE_LEFT_BULK  = 3'd0;
  localparam logic [2:0] ZONE_LEFT_MEMB  = 3'd1;
  localparam logic [2:0] ZONE_RIGHT_BULK = 3'd2;
  localparam logic [2:0] ZONE_RIGHT_MEMB = 3'd3;
  localparam logic [2:0] ZONE_NONE       = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_BOX_X       = 3'd0;
  localparam logic [2:0] REG_BOX_Y       = 3'd1;
  localparam logic [2:0] REG_BOX_Z       = 3'd2;
  localparam logic [2:0] REG_SLAB_ONE    = 3'd3;
  localparam logic [2:0] REG_SLAB_TWO    = 3'd4;
  localparam logic [2:0] REG_SLAB_THREE  = 3'd5;

  typedef struct packed {
    logic [2:0][REG_W-1:0] box;   // x, y, z
    logic [2:0][REG_W-1:0] slab;  // one, two, three
  } cfg_t;

  // One collision job as handed from the front to the back
  typedef struct packed {
    logic [2:0][VAL_W:0]   dr;    // p1 - p2, signed
    logic [2:0][VAL_W:0]   dv;    // v1 - v2, signed
    logic [2:0][VAL_W-1:0] v1;
    logic [2:0][VAL_W-1:0] v2;
    logic [REG_W-1:0]      m1;
    logic [REG_W-1:0]      m2;
    logic [REG_W-1:0]      sigma;
    logic [2:0]            zone;
  } job_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     dividend;
    logic [DEN_W-1:0]     divisor;
    logic [DIV_CNT_W-1:0] nbits;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [DEN_W-1:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/core/hspc_div.sv -----
// ----------------------------------------------------------------------------
// hspc_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hspc_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire hspc_pkg::div_req_t req,
  output hspc_pkg::div_rsp_t      rsp
);
  import hspc_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0]     num_r;
  logic [DIV_W-1:0]     q_r;
  logic [DEN_W-1:0]     rem_r;
  logic [DEN_W-1:0]     den_r;

  logic [DEN_W:0]       trial;
  logic                 ge;
  logic [DEN_W:0]       diff;

  assign trial = {rem_r, num_r[DIV_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.nbits;
        num_r  <= req.dividend;
        den_r  <= req.divisor;
        rem_r  <= '0;
        q_r    <= '0;
      end else if (busy_r) begin
        rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        q_r   <= {q_r[DIV_W-2:0], ge};
        num_r <= {num_r[DIV_W-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem  = rem_r;

endmodule

`default_nettype wire

// ----- rtl/core/hspc_queue.sv -----
// ----------------------------------------------------------------------------
// hspc_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module hspc_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire hspc_pkg::job_t push_job,
  input  wire logic           pop,
  output hspc_pkg::job_t      head_job,
  output logic                full,
  output logic                empty
);
  import hspc_pkg::*;

  job_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  assign full     = cnt_r == 2'd2;
  assign empty    = cnt_r == 2'd0;
  assign head_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        mem_r[wr_ptr_r] <= push_job;
        wr_ptr_r        <= ~wr_ptr_r;
      end
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/hspc_front.sv -----
// ----------------------------------------------------------------------------
// hspc_front
// Accepts beats, holds particle one, builds collision jobs and zone codes.
// ----------------------------------------------------------------------------
`default_nettype none

module hspc_front (
  input  wire logic        clk,
  input  wire hspc_pkg::cfg_t cfg,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_op,
  input  wire logic [31:0] in_pos_x,
  input  wire logic [31:0] in_pos_y,
  input  wire logic [31:0] in_pos_z,
  input  wire logic [31:0] in_vel_x,
  input  wire logic [31:0] in_vel_y,
  input  wire logic [31:0] in_vel_z,
  input  wire logic [30:0] in_particle_mass,
  input  wire logic [30:0] in_contact_dist,
  input  wire logic        q_full,
  output logic             push,
  output hspc_pkg::job_t   job
);
  import hspc_pkg::*;

  logic [2:0][VAL_W-1:0] hold_pos_r;
  logic [2:0][VAL_W-1:0] hold_vel_r;
  logic [REG_W-1:0]      hold_mass_r;
  logic [2:0][VAL_W-1:0] pos;
  logic [2:0][VAL_W-1:0] vel;
  logic                  accept;
  logic [2:0]            zone_one;
  logic [2:0]            zone_two;

  function automatic logic [2:0] slab_of(input logic [VAL_W-1:0] z, input cfg_t c);
    logic [REG_W-1:0] zm;
    zm = z[REG_W-1:0];
    if (z[VAL_W-1])                                       return ZONE_NONE;
    else if (zm < c.slab[0])                              return ZONE_LEFT_BULK;
    else if (zm >= c.slab[0] && zm < c.slab[1])           return ZONE_LEFT_MEMB;
    else if (zm >= c.slab[1] && zm < c.slab[2])           return ZONE_RIGHT_BULK;
    else if (zm >= c.slab[2] && zm < c.box[2])            return ZONE_RIGHT_MEMB;
    else                                                  return ZONE_NONE;
  endfunction

  assign pos      = {in_pos_z, in_pos_y, in_pos_x};
  assign vel      = {in_vel_z, in_vel_y, in_vel_x};
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = accept && (in_op == OP_COLLIDE);

  assign zone_one = slab_of(hold_pos_r[2], cfg);
  assign zone_two = slab_of(pos[2], cfg);

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      job.dr[a] = {hold_pos_r[a][VAL_W-1], hold_pos_r[a]} - {pos[a][VAL_W-1], pos[a]};
      job.dv[a] = {hold_vel_r[a][VAL_W-1], hold_vel_r[a]} - {vel[a][VAL_W-1], vel[a]};
    end
    job.v1    = hold_vel_r;
    job.v2    = vel;
    job.m1    = hold_mass_r;
    job.m2    = in_particle_mass;
    job.sigma = in_contact_dist;
    job.zone  = (zone_one == zone_two) ? zone_one : ZONE_NONE;
  end

  // particle one is held until the next load
  always_ff @(posedge clk) begin
    if (accept && in_op == OP_LOAD) begin
      hold_pos_r  <= pos;
      hold_vel_r  <= vel;
      hold_mass_r <= in_particle_mass;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/hspc_back.sv -----
// ----------------------------------------------------------------------------
// hspc_back
// Collision sequencer: minimum image, impulse and new velocities on a
// shared 32x32 multiplier and the iterative divider.
// ----------------------------------------------------------------------------
`default_nettype none

module hspc_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire hspc_pkg::cfg_t     cfg,
  input  wire logic               q_empty,
  input  wire hspc_pkg::job_t     q_job,
  output logic                    q_pop,
  output hspc_pkg::div_req_t      div_req,
  input  wire hspc_pkg::div_rsp_t div_rsp,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_which_particle,
  output logic [31:0]             out_new_vel_x,
  output logic [31:0]             out_new_vel_y,
  output logic [31:0]             out_new_vel_z,
  output logic [31:0]             out_virial_value,
  output logic [2:0]              out_zone,
  output logic                    out_last
);
  import hspc_pkg::*;

  localparam logic [60:0] ICAP = {1'b1, 60'b0};
  localparam logic [31:0] VCAP = {1'b1, 31'b0};

  typedef enum logic [4:0] {
    ST_IDLE, ST_MOD, ST_MOD_FIN, ST_BT, ST_BT_FIN, ST_RR_FIN, ST_S2_FIN,
    ST_K_FIN, ST_W1, ST_W1_FIN, ST_W2_FIN, ST_PM_FIN, ST_MU_FIN, ST_C1,
    ST_C1_FIN, ST_C2_FIN, ST_D, ST_D1_FIN, ST_D2_FIN, ST_KM_FIN, ST_VM_FIN,
    ST_OUT0, ST_OUT1, ST_MUL, ST_DIV
  } state_t;

  state_t state_r;
  state_t ret_r;
  logic [1:0] axis_r;
  job_t job_r;

  logic [2:0][VAL_W:0]   r_r;
  logic signed [51:0]    b_r;
  logic [50:0]           rr_r;
  logic [60:0]           k_r, c1_r, c2_r;
  logic [17:0]           w1_r, w2_r;
  logic [30:0]           mu2_r;
  logic [2:0][31:0]      nv0_r, nv1_r;

  logic [63:0]  mul_a_r, mul_b_r;
  logic [2:0]   mcnt_r;
  logic [63:0]  pp_r;
  logic [1:0]   pps_r;
  logic [127:0] acc_r;

  logic                 div_start_r;
  logic [DIV_W-1:0]     div_num_r;
  logic [DEN_W-1:0]     div_den_r;
  logic [DIV_CNT_W-1:0] div_n_r;

  logic        out_valid_r, which_r;
  logic [31:0] ovx_r, ovy_r, ovz_r, vir_r;
  logic [2:0]  zone_r;

  // combinational helpers
  logic [VAL_W:0]   r_cur, dv_cur, dr_cur;
  logic [31:0]      r_mag, dv_mag, dr_mag;
  logic [REG_W-1:0] len_cur, m_rem, u_img;
  logic             fold;
  logic [VAL_W:0]   r_img;
  logic [47:0]      prod_sh;
  logic [51:0]      b_mag;
  logic [31:0]      msum;
  logic             same;
  logic [31:0]      a_part, b_part;
  logic [127:0]     pp_ext;
  logic [31:0]      vm;
  logic             b_pos;

  function automatic logic [31:0] mag33(input logic [VAL_W:0] x);
    logic [VAL_W:0] m;
    m = x[VAL_W] ? (~x + 1'b1) : x;
    return m[31:0];
  endfunction

  function automatic logic [60:0] cap_i(input logic [127:0] p);
    if (|p[127:64]) return ICAP;
    else            return {13'b0, p[63:16]};
  endfunction

  function automatic logic [31:0] cap_v(input logic [127:0] p);
    if (|p[127:64])                 return VCAP;
    else if (p[63:16] > {16'b0, VCAP}) return VCAP;
    else                            return p[47:16];
  endfunction

  function automatic logic [31:0] add_sat(input logic [31:0] v, input logic [31:0] d,
                                          input logic neg);
    logic signed [33:0] s;
    logic signed [33:0] de;
    de = $signed({2'b0, d});
    s  = $signed({{2{v[31]}}, v}) + (neg ? -de : de);
    if (s > $signed(34'h0_7FFF_FFFF))      return 32'h7FFF_FFFF;
    else if (s < $signed(34'h3_8000_0000)) return 32'h8000_0000;
    else                                   return s[31:0];
  endfunction

  assign r_cur   = r_r[axis_r];
  assign dv_cur  = job_r.dv[axis_r];
  assign dr_cur  = job_r.dr[axis_r];
  assign r_mag   = mag33(r_cur);
  assign dv_mag  = mag33(dv_cur);
  assign dr_mag  = mag33(dr_cur);
  assign len_cur = cfg.box[axis_r];

  // fold the remainder into (-L/2, L/2]
  assign m_rem = div_rsp.rem[REG_W-1:0];
  assign u_img = !dr_cur[VAL_W] ? m_rem : ((m_rem == '0) ? '0 : len_cur - m_rem);
  assign fold  = {u_img, 1'b0} > {1'b0, len_cur};
  assign r_img = fold ? ({2'b0, u_img} - {2'b0, len_cur}) : {2'b0, u_img};

  assign prod_sh = acc_r[63:16];
  assign b_mag   = b_r[51] ? -b_r : b_r;
  assign msum    = {1'b0, job_r.m1} + {1'b0, job_r.m2};
  assign same    = r_cur[VAL_W] == b_r[51];
  assign vm      = cap_v(acc_r);
  assign b_pos   = !b_r[51] && (b_r != '0);

  assign a_part = mcnt_r[1] ? mul_a_r[63:32] : mul_a_r[31:0];
  assign b_part = mcnt_r[0] ? mul_b_r[63:32] : mul_b_r[31:0];

  always_comb begin
    case (pps_r)
      2'd0:    pp_ext = {64'b0, pp_r};
      2'd1:    pp_ext = {32'b0, pp_r, 32'b0};
      default: pp_ext = {pp_r, 64'b0};
    endcase
  end

  assign q_pop = (state_r == ST_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= ST_IDLE;
      out_valid_r <= 1'b0;
      div_start_r <= 1'b0;
      mcnt_r      <= '0;
      axis_r      <= '0;
    end else begin
      div_start_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            job_r  <= q_job;
            axis_r <= '0;
            b_r    <= '0;
            rr_r   <= '0;
            state_r <= ST_MOD;
          end
        end
        ST_MOD: begin
          if (len_cur == '0) begin
            r_r[axis_r] <= dr_cur;
            state_r     <= ST_BT;
          end else begin
            div_start_r <= 1'b1;
            div_num_r   <= {dr_mag, 52'b0};
            div_den_r   <= {32'b0, len_cur};
            div_n_r     <= DIV_CNT_W'(32);
            ret_r       <= ST_MOD_FIN;
            state_r     <= ST_DIV;
          end
        end
        ST_MOD_FIN: begin
          r_r[axis_r] <= r_img;
          state_r     <= ST_BT;
        end
        ST_BT: begin
          mul_a_r <= {32'b0, r_mag};
          mul_b_r <= {32'b0, dv_mag};
          acc_r   <= '0;
          mcnt_r  <= '0;
          ret_r   <= ST_BT_FIN;
          state_r <= ST_MUL;
        end
        ST_BT_FIN: begin
          if (r_cur[VAL_W] != dv_cur[VAL_W]) b_r <= b_r - $signed({4'b0, prod_sh});
          else                               b_r <= b_r + $signed({4'b0, prod_sh});
          mul_a_r <= {32'b0, r_mag};
          mul_b_r <= {32'b0, r_mag};
          acc_r   <= '0;
          mcnt_r  <= '0;
          ret_r   <= ST_RR_FIN;
          state_r <= ST_MUL;
        end
        ST_RR_FIN: begin
          rr_r <= rr_r + {3'b0, prod_sh};
          if (axis_r == 2'd2) begin
            mul_a_r <= {33'b0, job_r.sigma};
            mul_b_r <= {33'b0, job_r.sigma};
            acc_r   <= '0;
            mcnt_r  <= '0;
            ret_r   <= ST_S2_FIN;
            state_r <= ST_MUL;
          end else begin
            axis_r  <= axis_r + 1'b1;
            state_r <= ST_MOD;
          end
        end
        ST_S2_FIN: begin
          if (acc_r[61:0] == '0) begin
            k_r     <= '0;
            state_r <= ST_W1;
          end else begin
            div_start_r <= 1'b1;
            div_num_r   <= {b_mag[50:0], 33'b0};
            div_den_r   <= {1'b0, acc_r[61:0]};
            div_n_r     <= DIV_CNT_W'(83);
            ret_r       <= ST_K_FIN;
            state_r     <= ST_DIV;
          end
        end
        ST_K_FIN: begin
          k_r     <= (div_rsp.quot > {23'b0, ICAP}) ? ICAP : div_rsp.quot[60:0];
          state_r <= ST_W1;
        end
        ST_W1: begin
          if (msum == '0) begin
            w1_r    <= '0;
            w2_r    <= '0;
            mu2_r   <= '0;
            state_r <= ST_C1;
          end else begin
            div_start_r <= 1'b1;
            div_num_r   <= {job_r.m2, 53'b0};
            div_den_r   <= {31'b0, msum};
            div_n_r     <= DIV_CNT_W'(48);
            ret_r       <= ST_W1_FIN;
            state_r     <= ST_DIV;
          end
        end
        ST_W1_FIN: begin
          w1_r        <= div_rsp.quot[17:0];
          div_start_r <= 1'b1;
          div_num_r   <= {job_r.m1, 53'b0};
          div_den_r   <= {31'b0, msum};
          div_n_r     <= DIV_CNT_W'(48);
          ret_r       <= ST_W2_FIN;
          state_r     <= ST_DIV;
        end
        ST_W2_FIN: begin
          w2_r    <= div_rsp.quot[17:0];
          mul_a_r <= {33'b0, job_r.m1};
          mul_b_r <= {33'b0, job_r.m2};
          acc_r   <= '0;
          mcnt_r  <= '0;
          ret_r   <= ST_PM_FIN;
          state_r <= ST_MUL;
        end
        ST_PM_FIN: begin
          div_start_r <= 1'b1;
          div_num_r   <= {acc_r[61:0], 22'b0};
          div_den_r   <= {31'b0, msum};
          div_n_r     <= DIV_CNT_W'(63);
          ret_r       <= ST_MU_FIN;
          state_r     <= ST_DIV;
        end
        ST_MU_FIN: begin
          mu2_r   <= div_rsp.quot[30:0];
          state_r <= ST_C1;
        end
        ST_C1: begin
          mul_a_r <= {3'b0, k_r};
          mul_b_r <= {46'b0, w1_r};
          acc_r   <= '0;
          mcnt_r  <= '0;
          ret_r   <= ST_C1_FIN;
          state_r <= ST_MUL;
        end
        ST_C1_FIN: begin
          c1_r    <= cap_i(acc_r);
          mul_a_r <= {3'b0, k_r};
          mul_b_r <= {46'b0, w2_r};
          acc_r   <= '0;
          mcnt_r  <= '0;
          ret_r   <= ST_C2_FIN;
          state_r <= ST_MUL;
        end
        ST_C2_FIN: begin
          c2_r    <= cap_i(acc_r);
          axis_r  <= '0;
          state_r <= ST_D;
        end
        ST_D: begin
          mul_a_r <= {32'b0, r_mag};
          mul_b_r <= {3'b0, c1_r};
          acc_r   <= '0;
          mcnt_r  <= '0;
          ret_r   <= ST_D1_FIN;
          state_r <= ST_MUL;
        end
        ST_D1_FIN: begin
          nv0_r[axis_r] <= add_sat(job_r.v1[axis_r], vm, same);
          mul_a_r <= {32'b0, r_mag};
          mul_b_r <= {3'b0, c2_r};
          acc_r   <= '0;
          mcnt_r  <= '0;
          ret_r   <= ST_D2_FIN;
          state_r <= ST_MUL;
        end
        ST_D2_FIN: begin
          nv1_r[axis_r] <= add_sat(job_r.v2[axis_r], vm, !same);
          if (axis_r == 2'd2) begin
            mul_a_r <= {3'b0, k_r};
            mul_b_r <= {33'b0, mu2_r};
            acc_r   <= '0;
            mcnt_r  <= '0;
            ret_r   <= ST_KM_FIN;
            state_r <= ST_MUL;
          end else begin
            axis_r  <= axis_r + 1'b1;
            state_r <= ST_D;
          end
        end
        ST_KM_FIN: begin
          mul_a_r <= {3'b0, cap_i(acc_r)};
          mul_b_r <= {13'b0, rr_r};
          acc_r   <= '0;
          mcnt_r  <= '0;
          ret_r   <= ST_VM_FIN;
          state_r <= ST_MUL;
        end
        ST_VM_FIN: begin
          vir_r       <= add_sat(32'b0, vm, b_pos);
          zone_r      <= job_r.zone;
          which_r     <= 1'b0;
          ovx_r       <= nv0_r[0];
          ovy_r       <= nv0_r[1];
          ovz_r       <= nv0_r[2];
          out_valid_r <= 1'b1;
          state_r     <= ST_OUT0;
        end
        ST_OUT0: begin
          if (!out_stall) begin
            which_r <= 1'b1;
            ovx_r   <= nv1_r[0];
            ovy_r   <= nv1_r[1];
            ovz_r   <= nv1_r[2];
            state_r <= ST_OUT1;
          end
        end
        ST_OUT1: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        ST_MUL: begin
          // four 32x32 partial products, each registered before accumulation
          if (mcnt_r != 3'd4) begin
            pp_r  <= a_part * b_part;
            pps_r <= {1'b0, mcnt_r[1]} + {1'b0, mcnt_r[0]};
          end
          if (mcnt_r != 3'd0) acc_r <= acc_r + pp_ext;
          if (mcnt_r == 3'd4) state_r <= ret_r;
          else                mcnt_r  <= mcnt_r + 1'b1;
        end
        ST_DIV: begin
          if (div_rsp.done) state_r <= ret_r;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign div_req.start    = div_start_r;
  assign div_req.dividend = div_num_r;
  assign div_req.divisor  = div_den_r;
  assign div_req.nbits    = div_n_r;

  assign out_valid          = out_valid_r;
  assign out_which_particle = which_r;
  assign out_last           = which_r;
  assign out_new_vel_x      = ovx_r;
  assign out_new_vel_y      = ovy_r;
  assign out_new_vel_z      = ovz_r;
  assign out_virial_value   = vir_r;
  assign out_zone           = zone_r;

endmodule

`default_nettype wire

// ----- rtl/core/hard_sphere_pair_collision.sv -----
// ----------------------------------------------------------------------------
// hard_sphere_pair_collision
// Elastic collision of two hard spheres in a periodic box, signed Q16.16.
// ----------------------------------------------------------------------------
// A collision takes two input beats: op 0 loads particle one (held in the
// front until the next load), op 1 brings particle two and the contact
// distance. Each op 1 beat yields two result beats, particle one first, then
// particle two with last set; both carry the same virial and zone. A
// collision is queued (two jobs deep) and then runs on the back sequencer:
// the radix-2 divider produces one quotient bit per cycle (3 x 32 bits for
// the minimum image, 83 for b / sigma^2, 2 x 48 for the mass weights, 63
// for the reduced mass, 338 bits in all) and the shared 32x32 multiplier
// computes 18 products. An axis with a zero box length skips its division.
// The back works on one collision at a time; the divider, the multiplier
// and out_stall set the rate. Velocities and the virial saturate to the
// signed 32-bit range. Configuration registers (box lengths and slab
// bounds, 31 bits each) sit on the APB port at byte address 4*i and are to
// be written only while no collision is in flight; the user must keep to
// this, the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module hard_sphere_pair_collision (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // input beats
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_op,
  input  wire logic [31:0] in_pos_x,
  input  wire logic [31:0] in_pos_y,
  input  wire logic [31:0] in_pos_z,
  input  wire logic [31:0] in_vel_x,
  input  wire logic [31:0] in_vel_y,
  input  wire logic [31:0] in_vel_z,
  input  wire logic [30:0] in_particle_mass,
  input  wire logic [30:0] in_contact_dist,
  // result beats
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_which_particle,
  output logic [31:0]      out_new_vel_x,
  output logic [31:0]      out_new_vel_y,
  output logic [31:0]      out_new_vel_z,
  output logic [31:0]      out_virial_value,
  output logic [2:0]       out_zone,
  output logic             out_last
);
  import hspc_pkg::*;

  logic [REG_W-1:0] box_x_r, box_y_r, box_z_r;
  logic [REG_W-1:0] slab_one_r, slab_two_r, slab_three_r;
  logic             cfg_wr;
  logic [2:0]       reg_idx;
  cfg_t             cfg;

  logic     q_full, q_empty, q_push, q_pop;
  job_t     push_job, head_job;
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  // register file; writes to unused addresses are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_x_r      <= 31'd655360;
      box_y_r      <= 31'd655360;
      box_z_r      <= 31'd655360;
      slab_one_r   <= 31'd163840;
      slab_two_r   <= 31'd327680;
      slab_three_r <= 31'd491520;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_BOX_X:      box_x_r      <= pwdata[REG_W-1:0];
        REG_BOX_Y:      box_y_r      <= pwdata[REG_W-1:0];
        REG_BOX_Z:      box_z_r      <= pwdata[REG_W-1:0];
        REG_SLAB_ONE:   slab_one_r   <= pwdata[REG_W-1:0];
        REG_SLAB_TWO:   slab_two_r   <= pwdata[REG_W-1:0];
        REG_SLAB_THREE: slab_three_r <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BOX_X:      prdata = {1'b0, box_x_r};
      REG_BOX_Y:      prdata = {1'b0, box_y_r};
      REG_BOX_Z:      prdata = {1'b0, box_z_r};
      REG_SLAB_ONE:   prdata = {1'b0, slab_one_r};
      REG_SLAB_TWO:   prdata = {1'b0, slab_two_r};
      REG_SLAB_THREE: prdata = {1'b0, slab_three_r};
      default:        prdata = 32'b0;
    endcase
  end

  assign cfg.box  = {box_z_r, box_y_r, box_x_r};
  assign cfg.slab = {slab_three_r, slab_two_r, slab_one_r};

  // front: take beats, hold particle one, classify zone, build the job
  hspc_front u_front (
    .clk              (clk),
    .cfg              (cfg),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_pos_z         (in_pos_z),
    .in_vel_x         (in_vel_x),
    .in_vel_y         (in_vel_y),
    .in_vel_z         (in_vel_z),
    .in_particle_mass (in_particle_mass),
    .in_contact_dist  (in_contact_dist),
    .q_full           (q_full),
    .push             (q_push),
    .job              (push_job)
  );

  // decouple the front from the long-running back
  hspc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  hspc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // back: sequence the arithmetic and present both result beats
  hspc_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .q_empty            (q_empty),
    .q_job              (head_job),
    .q_pop              (q_pop),
    .div_req            (div_req),
    .div_rsp            (div_rsp),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_which_particle (out_which_particle),
    .out_new_vel_x      (out_new_vel_x),
    .out_new_vel_y      (out_new_vel_y),
    .out_new_vel_z      (out_new_vel_z),
    .out_virial_value   (out_virial_value),
    .out_zone           (out_zone),
    .out_last           (out_last)
  );

endmodule

`default_nettype wire
